### rtl/core/pht_pkg.sv
// Shared types and constants for the pending handshake table.
package pht_pkg;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 64;
  localparam int SLOT_W   = 3;
  localparam int XCOUNT_W = 4;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 64'd10000000;

  // Command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_ALLOC  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_EXPIRE = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_MISS    = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_REFRESH = 3'd2;
  localparam logic [2:0] ST_NEW     = 3'd3;
  localparam logic [2:0] ST_EVICT   = 3'd4;
  localparam logic [2:0] ST_FREED   = 3'd5;
  localparam logic [2:0] ST_REJECT  = 3'd6;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  peer_key;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    evicted_key;
    logic [XCOUNT_W-1:0] expired_count;
  } out_item_t;

  // Scan control from the sequencer to the compare unit
  typedef struct packed {
    logic start;   // clear accumulators for a new command
    logic chk;     // entry data is valid this cycle
    logic expire;  // current command is an expire tick
  } scan_ctrl_t;

  // Valid-bit write request
  typedef struct packed {
    logic we;
    logic val;
  } vld_op_t;

endpackage

### rtl/core/pht_store.sv
// Entry storage: key and time memories with per-entry valid bits.
module pht_store #(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [pht_pkg::KEY_W-1:0]  rd_key,
  output logic [pht_pkg::TIME_W-1:0] rd_time,
  output logic                       rd_vld,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [pht_pkg::KEY_W-1:0]  wr_key,
  input  logic [pht_pkg::TIME_W-1:0] wr_time,
  input  pht_pkg::vld_op_t           vld_op,
  input  logic [IDX_W-1:0]           vld_idx
);

  logic [pht_pkg::KEY_W-1:0]  key_mem  [ENTRIES];
  logic [pht_pkg::TIME_W-1:0] time_mem [ENTRIES];
  logic [ENTRIES-1:0]         valid_r;
  logic [pht_pkg::KEY_W-1:0]  rd_key_r;
  logic [pht_pkg::TIME_W-1:0] rd_time_r;
  logic                       rd_vld_r;

  // Write one entry, read one entry, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      time_mem[wr_addr] <= wr_time;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_time_r <= time_mem[rd_addr];
  end

  // Hold valid bits, cleared on reset; a free entry reads with rd_vld low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (vld_op.we) begin
        valid_r[vld_idx] <= vld_op.val;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_key  = rd_key_r;
  assign rd_time = rd_time_r;
  assign rd_vld  = rd_vld_r;

endmodule

### rtl/core/pht_scan.sv
// Shared compare unit: checks one entry per cycle and accumulates scan results.
module pht_scan #(
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pht_pkg::scan_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]           chk_idx,
  input  logic [pht_pkg::KEY_W-1:0]  e_key,
  input  logic [pht_pkg::TIME_W-1:0] e_time,
  input  logic                       e_vld,
  input  logic [pht_pkg::KEY_W-1:0]  key,
  input  logic [pht_pkg::TIME_W-1:0] now,
  input  logic [pht_pkg::TIME_W-1:0] timeout,
  output logic                       found,
  output logic [IDX_W-1:0]           found_idx,
  output logic                       free_found,
  output logic [IDX_W-1:0]           free_idx,
  output logic [IDX_W-1:0]           min_idx,
  output logic [pht_pkg::KEY_W-1:0]  min_key,
  output logic [CNT_W-1:0]           exp_cnt,
  output logic                       exp_clr
);

  logic                       found_r;
  logic [IDX_W-1:0]           found_idx_r;
  logic                       free_found_r;
  logic [IDX_W-1:0]           free_idx_r;
  logic [IDX_W-1:0]           min_idx_r;
  logic [pht_pkg::TIME_W-1:0] min_time_r;
  logic [pht_pkg::KEY_W-1:0]  min_key_r;
  logic [CNT_W-1:0]           exp_cnt_r;

  logic [pht_pkg::TIME_W-1:0] op_a;
  logic [pht_pkg::TIME_W-1:0] op_b;
  logic [pht_pkg::TIME_W:0]   diff;
  logic                       lt;
  logic                       age_over;
  logic                       hit;
  logic                       first;
  logic                       take_min;

  // Share one subtractor: modular age for expire, time order for eviction
  always_comb begin
    op_a     = ctrl.expire ? now : e_time;
    op_b     = ctrl.expire ? e_time : min_time_r;
    diff     = {1'b0, op_a} - {1'b0, op_b};
    lt       = diff[pht_pkg::TIME_W];
    age_over = diff[pht_pkg::TIME_W-1:0] > timeout;
    hit      = e_vld && (e_key == key);
    first    = (chk_idx == '0);
    take_min = ctrl.chk && !ctrl.expire && (first || lt);
    exp_clr  = ctrl.chk && ctrl.expire && e_vld && age_over;
  end

  // Track first match, first free entry and expire count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      exp_cnt_r    <= '0;
    end else if (ctrl.start) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      exp_cnt_r    <= '0;
    end else if (ctrl.chk) begin
      if (hit && !found_r) begin
        found_r <= 1'b1;
      end
      if (!e_vld && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (exp_clr) begin
        exp_cnt_r <= exp_cnt_r + CNT_W'(1);
      end
    end
  end

  // Capture indexes and the oldest entry (strict less keeps lowest index)
  always_ff @(posedge clk) begin
    if (ctrl.chk && hit && !found_r) begin
      found_idx_r <= chk_idx;
    end
    if (ctrl.chk && !e_vld && !free_found_r) begin
      free_idx_r <= chk_idx;
    end
    if (take_min) begin
      min_idx_r  <= chk_idx;
      min_time_r <= e_time;
      min_key_r  <= e_key;
    end
  end

  assign found      = found_r;
  assign found_idx  = found_idx_r;
  assign free_found = free_found_r;
  assign free_idx   = free_idx_r;
  assign min_idx    = min_idx_r;
  assign min_key    = min_key_r;
  assign exp_cnt    = exp_cnt_r;

endmodule

### rtl/core/pending_handshake_table_top.sv
// Pending handshake table: sequencer, timeout register and result register.
// One command at a time: start is taken only while idle, and busy stays high through
// the scan, which reads one entry per cycle through the single memory read port.
// busy drops in the cycle the result is shown; the receiver cannot stall.
// Reset (rst_n, synchronous): all entries free, timeout_us = 10000000.
module pending_handshake_table_top #(
  parameter int ENTRIES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  pht_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output pht_pkg::out_item_t         out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pht_pkg::TIME_W-1:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  pht_pkg::in_item_t          item_r;
  logic [pht_pkg::TIME_W-1:0] timeout_r;
  logic [IDX_W-1:0]           rd_addr_r;
  logic                       issue_r;
  logic                       chk_r;
  logic [IDX_W-1:0]           chk_idx_r;
  logic                       chk_last_r;
  logic                       out_valid_r;
  pht_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                       accept;
  pht_pkg::scan_ctrl_t        sctrl;
  logic [pht_pkg::KEY_W-1:0]  e_key;
  logic [pht_pkg::TIME_W-1:0] e_time;
  logic                       e_vld;
  logic                       found;
  logic [IDX_W-1:0]           found_idx;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;
  logic [IDX_W-1:0]           min_idx;
  logic [pht_pkg::KEY_W-1:0]  min_key;
  logic [CNT_W-1:0]           exp_cnt;
  logic                       exp_clr;

  logic                       reject;
  logic                       fin_wr;
  logic [IDX_W-1:0]           fin_idx;
  pht_pkg::vld_op_t           fin_vop;
  pht_pkg::vld_op_t           vld_op;
  logic [IDX_W-1:0]           vld_idx;
  logic [IDX_W+2:0]           slot_ext;
  logic [CNT_W+3:0]           cnt_ext;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  assign sctrl.start  = accept;
  assign sctrl.chk    = chk_r;
  assign sctrl.expire = (item_r.cmd == pht_pkg::CMD_EXPIRE);

  pht_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr_r),
    .rd_key  (e_key),
    .rd_time (e_time),
    .rd_vld  (e_vld),
    .wr_en   (fin_wr),
    .wr_addr (fin_idx),
    .wr_key  (item_r.peer_key),
    .wr_time (item_r.now_us),
    .vld_op  (vld_op),
    .vld_idx (vld_idx)
  );

  pht_scan #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (sctrl),
    .chk_idx    (chk_idx_r),
    .e_key      (e_key),
    .e_time     (e_time),
    .e_vld      (e_vld),
    .key        (item_r.peer_key),
    .now        (item_r.now_us),
    .timeout    (timeout_r),
    .found      (found),
    .found_idx  (found_idx),
    .free_found (free_found),
    .free_idx   (free_idx),
    .min_idx    (min_idx),
    .min_key    (min_key),
    .exp_cnt    (exp_cnt),
    .exp_clr    (exp_clr)
  );

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_r && chk_last_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Decide the result and the table update after the scan
  always_comb begin
    reject       = (item_r.cmd != pht_pkg::CMD_EXPIRE) && (item_r.peer_key == '0);
    fin_wr       = 1'b0;
    fin_idx      = '0;
    fin_vop.we   = 1'b0;
    fin_vop.val  = 1'b0;
    out_item_nxt = '0;
    cnt_ext      = {4'b0, exp_cnt};
    if (reject) begin
      out_item_nxt.status = pht_pkg::ST_REJECT;
    end else begin
      case (item_r.cmd)
        pht_pkg::CMD_EXPIRE: begin
          out_item_nxt.status        = (exp_cnt != '0) ? pht_pkg::ST_FREED : pht_pkg::ST_MISS;
          out_item_nxt.expired_count = cnt_ext[3:0];
        end
        pht_pkg::CMD_LOOKUP: begin
          if (found) begin
            out_item_nxt.status = pht_pkg::ST_HIT;
            fin_idx             = found_idx;
          end
        end
        pht_pkg::CMD_CLEAR: begin
          if (found) begin
            out_item_nxt.status        = pht_pkg::ST_FREED;
            out_item_nxt.expired_count = pht_pkg::XCOUNT_W'(1);
            fin_idx                    = found_idx;
            fin_vop.we                 = 1'b1;
            fin_vop.val                = 1'b0;
          end
        end
        pht_pkg::CMD_ALLOC: begin
          fin_wr      = 1'b1;
          fin_vop.we  = 1'b1;
          fin_vop.val = 1'b1;
          if (found) begin
            out_item_nxt.status = pht_pkg::ST_REFRESH;
            fin_idx             = found_idx;
          end else if (free_found) begin
            out_item_nxt.status = pht_pkg::ST_NEW;
            fin_idx             = free_idx;
          end else begin
            out_item_nxt.status      = pht_pkg::ST_EVICT;
            out_item_nxt.evicted_key = min_key;
            fin_idx                  = min_idx;
          end
        end
        default: begin
          out_item_nxt.status = pht_pkg::ST_MISS;
        end
      endcase
    end
    slot_ext          = {3'b0, fin_idx};
    out_item_nxt.slot = slot_ext[2:0];
    if (state_r != S_FIN) begin
      fin_wr     = 1'b0;
      fin_vop.we = 1'b0;
    end
  end

  // Drop valid bits during an expire scan, else apply the final update
  always_comb begin
    if (state_r == S_FIN) begin
      vld_op  = fin_vop;
      vld_idx = fin_idx;
    end else begin
      vld_op.we  = exp_clr;
      vld_op.val = 1'b0;
      vld_idx    = chk_idx_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= pht_pkg::TIMEOUT_RESET;
      rd_addr_r   <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      chk_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN);
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      chk_r      <= (state_r == S_SCAN) && issue_r;
      chk_last_r <= (rd_addr_r == LAST_IDX);
      if (accept) begin
        rd_addr_r <= '0;
        issue_r   <= 1'b1;
      end else if ((state_r == S_SCAN) && issue_r) begin
        if (rd_addr_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          rd_addr_r <= rd_addr_r + IDX_W'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx_r <= rd_addr_r;
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == S_FIN) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### dv/pht_reply_checker.sv
// Reply checker for the pending handshake table: predicts each command's reply and compares.
module pht_reply_checker #(
  parameter int ENTRIES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  pht_pkg::in_item_t          in_item,
  input  logic                       out_valid,
  input  pht_pkg::out_item_t         out_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [pht_pkg::TIME_W-1:0] cfg_data,
  output int                         replies_owed,
  output int                         mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import pht_pkg::*;

  localparam int MAX_PRINTED = 40;

  // Shadow copy of the table and the timeout register
  logic [KEY_W-1:0]  peer_tab  [ENTRIES];
  logic [TIME_W-1:0] stamp_tab [ENTRIES];
  logic [TIME_W-1:0] timeout_us_q;

  out_item_t expected_replies [$];
  int        replies_checked;

  // Apply one command to the shadow table and return the reply it must produce
  function automatic out_item_t predict_reply(in_item_t req);
    out_item_t         r;
    logic [TIME_W-1:0] age;
    int                found;
    int                free_idx;
    int                oldest;
    int                idx;
    int                freed;
    r        = '0;
    found    = -1;
    free_idx = -1;
    oldest   = 0;
    freed    = 0;
    idx      = 0;
    // Locate the key, the first free entry and the oldest entry (lowest index on ties)
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && peer_tab[i] == req.peer_key) found = i;
      if (free_idx < 0 && peer_tab[i] == '0) free_idx = i;
      if (stamp_tab[i] < stamp_tab[oldest]) oldest = i;
    end
    if (req.cmd == CMD_EXPIRE) begin
      // Drop every used entry whose wrapped age exceeds the timeout
      for (int i = 0; i < ENTRIES; i++) begin
        age = req.now_us - stamp_tab[i];
        if (peer_tab[i] != '0 && age > timeout_us_q) begin
          peer_tab[i]  = '0;
          stamp_tab[i] = '0;
          freed++;
        end
      end
      r.status        = (freed != 0) ? ST_FREED : ST_MISS;
      r.expired_count = XCOUNT_W'(freed);
    end else if (req.peer_key == '0) begin
      r.status = ST_REJECT;
    end else if (req.cmd == CMD_LOOKUP) begin
      // A miss leaves the all-zero reply
      if (found >= 0) begin
        r.status = ST_HIT;
        r.slot   = SLOT_W'(found);
      end
    end else if (req.cmd == CMD_CLEAR) begin
      if (found >= 0) begin
        peer_tab[found]  = '0;
        stamp_tab[found] = '0;
        r.status         = ST_FREED;
        r.slot           = SLOT_W'(found);
        r.expired_count  = XCOUNT_W'(1);
      end
    end else begin
      // Allocate: refresh, else take a free entry, else evict the oldest
      if (found >= 0) begin
        stamp_tab[found] = req.now_us;
        r.status         = ST_REFRESH;
        idx              = found;
      end else begin
        if (free_idx >= 0) begin
          idx      = free_idx;
          r.status = ST_NEW;
        end else begin
          idx           = oldest;
          r.evicted_key = peer_tab[idx];
          r.status      = ST_EVICT;
        end
        peer_tab[idx]  = req.peer_key;
        stamp_tab[idx] = req.now_us;
      end
      r.slot = SLOT_W'(idx);
    end
    return r;
  endfunction

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] reply %0d: %s got 0x%0h, expected 0x%0h",
               $time, replies_checked, field, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int        delta;
    if (!rst_n) begin
      timeout_us_q = TIMEOUT_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        peer_tab[i]  = '0;
        stamp_tab[i] = '0;
      end
      expected_replies.delete();
      replies_checked = 0;
      mismatch_count  = 0;
      replies_owed   <= 0;
    end else begin
      delta = 0;
      // Take a register write first
      if (cfg_valid && cfg_ready) timeout_us_q = cfg_data;
      // Retire the oldest expectation against the reply on the bus
      if (out_valid !== 1'b0) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing pending, status", 64'(out_item.status), '0);
        end else begin
          want = expected_replies.pop_front();
          delta--;
          if (out_item.status !== want.status)
            report_mismatch("status", 64'(out_item.status), 64'(want.status));
          if (out_item.slot !== want.slot)
            report_mismatch("slot", 64'(out_item.slot), 64'(want.slot));
          if (out_item.evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", out_item.evicted_key, want.evicted_key);
          if (out_item.expired_count !== want.expired_count)
            report_mismatch("expired_count", 64'(out_item.expired_count),
                            64'(want.expired_count));
        end
        replies_checked++;
      end
      // Predict the reply of an accepted command transaction
      if (start && !busy) begin
        expected_replies.push_back(predict_reply(in_item));
        delta++;
      end
      replies_owed <= replies_owed + delta;
    end
  end

endmodule

### dv/tb_pending_handshake_table_top.sv
// Testbench top for the pending handshake table: stimulus, watchdog and verdict.
module tb_pending_handshake_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pht_pkg::*;

  localparam int ENTRIES    = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int POOL_N     = 12;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  in_item_t          in_item   = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data  = '0;

  int replies_owed;
  int mismatch_count;
  int idle_cycles = 0;
  int burst_left  = 0;

  logic [KEY_W-1:0]  key_pool [POOL_N];
  logic [TIME_W-1:0] clock_us = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  pending_handshake_table_top #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  pht_reply_checker #(
    .ENTRIES(ENTRIES)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .replies_owed  (replies_owed),
    .mismatch_count(mismatch_count)
  );

  // Abort when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** pending_handshake_table_top: FAILED **");
        $finish;
      end
    end
  end

  // Present one command and hold it until the block takes it
  task automatic issue(input logic [1:0] op, input logic [KEY_W-1:0] key,
                       input logic [TIME_W-1:0] stamp);
    in_item <= '{cmd: op, peer_key: key, now_us: stamp};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted reply has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0 || busy) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic under one timeout: mostly pool keys so entries get hit and evicted
  task automatic run_phase(input logic [TIME_W-1:0] tmo, input int n_items, input bit gappy);
    logic [KEY_W-1:0] key;
    logic [1:0]       op;
    int               pick;
    int               step_max;
    write_timeout(tmo);
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    step_max = (tmo < 64'd3000) ? int'(tmo) / 3 + 2 : 3000;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 40) ? CMD_ALLOC : (pick < 65) ? CMD_LOOKUP :
             (pick < 82) ? CMD_CLEAR : CMD_EXPIRE;
      pick = $urandom_range(0, 99);
      key  = (pick < 82) ? key_pool[$urandom_range(0, POOL_N - 1)] :
             (pick < 94) ? {$urandom, $urandom} : '0;
      // Advance time: small steps, a jump across the timeout, or a random wrap
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        clock_us = {$urandom, $urandom};
      end else if (pick < 12) begin
        clock_us = clock_us + tmo + $urandom_range(0, 2);
      end else begin
        clock_us = clock_us + $urandom_range(0, step_max);
      end
      if (n == n_items / 2) drain();
      issue(op, key, clock_us);
      if (gappy) begin
        if (burst_left == 0) begin
          pause($urandom_range(1, 24));
          burst_left = $urandom_range(1, 16);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero keys are rejected; empty table misses everywhere
    issue(CMD_LOOKUP, '0, 64'd5);
    issue(CMD_ALLOC, '0, 64'd5);
    issue(CMD_CLEAR, '0, 64'd5);
    issue(CMD_EXPIRE, '1, '1);
    issue(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 64'd7);
    issue(CMD_CLEAR, 64'h0123_4567_89AB_CDEF, 64'd7);

    // Fill all entries, with a tie on the smallest time and one time at the top
    issue(CMD_ALLOC, '1, 64'd500);
    issue(CMD_ALLOC, 64'h0000_0000_0000_0001, 64'd100);
    issue(CMD_ALLOC, 64'h8000_0000_0000_0000, 64'd100);
    issue(CMD_ALLOC, 64'hA5A5_A5A5_A5A5_A5A5, 64'd300);
    issue(CMD_ALLOC, 64'h5A5A_5A5A_5A5A_5A5A, 64'd300);
    issue(CMD_ALLOC, 64'h0123_4567_89AB_CDEF, '1);
    issue(CMD_ALLOC, 64'hFEDC_BA98_7654_3210, 64'd300);
    issue(CMD_ALLOC, 64'h0000_0001_0000_0000, 64'd300);

    // Hit, refresh to the oldest time, then evict twice (the second on a tie)
    issue(CMD_LOOKUP, 64'h0000_0001_0000_0000, 64'd0);
    issue(CMD_ALLOC, 64'hA5A5_A5A5_A5A5_A5A5, 64'd50);
    issue(CMD_ALLOC, 64'h1111_2222_3333_4444, 64'd1000);
    issue(CMD_ALLOC, 64'h5555_6666_7777_8888, 64'd1000);

    // Clear one entry and reuse the freed slot
    issue(CMD_CLEAR, '1, 64'd0);
    issue(CMD_ALLOC, 64'h9999_AAAA_BBBB_CCCC, 64'd2000);

    // Expire with a wrapped age, then again with nothing left to drop
    issue(CMD_EXPIRE, 64'h0BAD_0BAD_0BAD_0BAD, 64'd10_000_200);
    issue(CMD_EXPIRE, '0, 64'd10_000_200);

    // Zero timeout frees every entry that has aged at all
    write_timeout('0);
    issue(CMD_EXPIRE, 64'h0F0F_0F0F_0F0F_0F0F, 64'd2000);
    issue(CMD_LOOKUP, 64'h9999_AAAA_BBBB_CCCC, 64'd0);

    // Random phases over a spread of timeouts, the extremes among them
    run_phase('1, 110, 1'b1);
    run_phase(64'd20, 110, 1'b1);
    run_phase(64'd1000, 110, 1'b0);
    run_phase({$urandom, $urandom}, 100, 1'b1);
    run_phase('0, 40, 1'b1);
    run_phase(TIMEOUT_RESET, 100, 1'b1);
    run_phase(64'd5, 80, 1'b1);

    // Let the last replies land and catch any stray strobe
    drain();
    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatch_count == 0 && replies_owed == 0) begin
      $display("** pending_handshake_table_top: PASSED **");
    end else begin
      $display("** pending_handshake_table_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pht_pkg.sv
rtl/core/pht_store.sv
rtl/core/pht_scan.sv
rtl/core/pending_handshake_table_top.sv
dv/pht_reply_checker.sv
dv/tb_pending_handshake_table_top.sv
